// File: hw/rtl/eas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eas_pkg;

    localparam int FRAC_BITS = 12;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int T_W       = 12;

    localparam logic [Q_W-1:0] Q_ONE     = Q_W'(1 << FRAC_BITS);
    localparam logic [Q_W-1:0] VIS_LIMIT = Q_W'(4);

    localparam logic [1:0] ANIM_NONE  = 2'd0;
    localparam logic [1:0] ANIM_LOOK  = 2'd1;
    localparam logic [1:0] ANIM_WINK  = 2'd2;
    localparam logic [1:0] ANIM_SMILE = 2'd3;

    localparam logic [31:0] LCG_MUL    = 32'd1103515245;
    localparam logic [31:0] LCG_INC    = 32'd12345;
    localparam logic [32:0] BUSY_DELAY = 33'd5000;

    localparam logic [1:0] CFG_MIN_GAP = 2'd0;
    localparam logic [1:0] CFG_MAX_GAP = 2'd1;
    localparam logic [1:0] CFG_SEED    = 2'd2;

    // shared divider geometry
    localparam int DIV_NUM_W   = 41;
    localparam int DIV_DEN_W   = 32;
    localparam int DIV_Q_W     = 31;
    localparam int DIV_CNT_W   = 5;
    localparam int DIV_LONG_N  = 31;
    localparam int DIV_SHORT_N = FRAC_BITS + 1;

    typedef struct packed {
        logic start;
        logic long_mode;
    } t_div_req;

    typedef struct packed {
        logic [T_W-1:0] t0;
        logic [T_W-1:0] t1;
    } t_span;

    function automatic logic [T_W-1:0] anim_len(input logic [1:0] kind);
        logic [T_W-1:0] len;
        case (kind)
            ANIM_LOOK:  len = T_W'(3200);
            ANIM_WINK:  len = T_W'(2600);
            ANIM_SMILE: len = T_W'(3000);
            default:    len = '0;
        endcase
        return len;
    endfunction

    function automatic t_span mk_span(input int a, input int b);
        t_span s;
        s.t0 = T_W'(a);
        s.t1 = T_W'(b);
        return s;
    endfunction

    // rising ramp windows for each animation, slot by slot
    function automatic t_span ramp_span(input logic [1:0] kind, input logic [2:0] idx,
                                        input logic [T_W-1:0] t);
        t_span s;
        s = mk_span(0, 260);
        case (idx)
            3'd0: s = mk_span(0, 260);
            3'd1: begin
                case (kind)
                    ANIM_LOOK: s = mk_span(2940, 3200);
                    ANIM_WINK: s = mk_span(2340, 2600);
                    default:   s = mk_span(2740, 3000);
                endcase
            end
            3'd2: s = mk_span(180, 420);
            3'd3: begin
                case (kind)
                    ANIM_LOOK: s = mk_span(2700, 2940);
                    ANIM_WINK: s = mk_span(2100, 2340);
                    default:   s = mk_span(1000, 1200);
                endcase
            end
            default: begin
                case (kind)
                    ANIM_LOOK: begin
                        if (t < T_W'(1150))
                            s = mk_span(700, 1150);
                        else if (t < T_W'(2050))
                            s = mk_span(1450, 2050);
                        else
                            s = mk_span(2350, 2650);
                    end
                    ANIM_WINK: begin
                        if (t < T_W'(1100))
                            s = mk_span(900, 1100);
                        else
                            s = mk_span(1260, 1460);
                    end
                    default: begin
                        if (idx == 3'd4)
                            s = mk_span(1200, 1400);
                        else
                            s = mk_span(2300, 2500);
                    end
                endcase
            end
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/eas_div.sv
`timescale 1ns / 1ps
`default_nettype none

module eas_div import eas_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_div_req             i_req,
    input  wire logic [DIV_NUM_W-1:0] i_num,
    input  wire logic [DIV_DEN_W-1:0] i_den,
    output logic                      o_busy,
    output logic [DIV_Q_W-1:0]        o_quot,
    output logic [DIV_DEN_W-1:0]      o_rem
);

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_sh;
    logic [DIV_Q_W-1:0]   r_quot;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    // one restoring step per cycle
    assign trial = {r_rem, r_sh[DIV_NUM_W-1]};
    assign fits  = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= i_req.long_mode ? DIV_CNT_W'(DIV_LONG_N) : DIV_CNT_W'(DIV_SHORT_N);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= '0;
            if (i_req.long_mode) begin
                r_rem <= '0;
                r_sh  <= {i_num[DIV_LONG_N-1:0], (DIV_NUM_W-DIV_LONG_N)'(0)};
            end else begin
                // quotient fits in the short step count, so the top bits start the remainder
                r_rem <= DIV_DEN_W'(i_num[DIV_NUM_W-1:DIV_SHORT_N]);
                r_sh  <= {i_num[DIV_SHORT_N-1:0], (DIV_NUM_W-DIV_SHORT_N)'(0)};
            end
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? DIV_DEN_W'(trial - {1'b0, i_den}) : DIV_DEN_W'(trial);
            r_sh   <= {r_sh[DIV_NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_Q_W-2:0], fits};
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// File: hw/rtl/eye_animation_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                    payload
// tick in   in         i_in_valid / o_in_ready      i_now_ms, i_restart, i_trigger, i_busy_req
// frame out out        o_out_valid / i_out_ready    o_active .. o_presence
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one tick at a time: when nothing runs, a tick passes the restart, trigger, schedule and frame
// states to the output state, which stores the frame once there is room; a drawn frame has six
// ramp slots, set directly when saturated or by four shared-multiplier multiplies and 13 divider
// steps inside the ramp, then three more multiplies; a gap draw adds 31 divider steps (modulo).
// synchronous active-low reset; state returns to no animation, seed one.
// a finished frame waits in the output register; a new tick is taken once it is stored.

module eye_animation_sequencer import eas_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [31:0]        i_now_ms,
    input  wire logic               i_restart,
    input  wire logic               i_trigger,
    input  wire logic               i_busy_req,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic                    o_active,
    output logic                    o_visible,
    output logic [1:0]              o_anim_kind,
    output logic [12:0]             o_open_left,
    output logic [12:0]             o_open_right,
    output logic signed [13:0]      o_gaze,
    output logic [12:0]             o_smile_amount,
    output logic [12:0]             o_presence,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_RESTART = 5'd1;
    localparam logic [4:0] ST_TRIG    = 5'd2;
    localparam logic [4:0] ST_SCHED   = 5'd3;
    localparam logic [4:0] ST_DRAW    = 5'd4;
    localparam logic [4:0] ST_DIVGO   = 5'd5;
    localparam logic [4:0] ST_DIVWAIT = 5'd6;
    localparam logic [4:0] ST_FRAME   = 5'd7;
    localparam logic [4:0] ST_RSET    = 5'd8;
    localparam logic [4:0] ST_RM1     = 5'd9;
    localparam logic [4:0] ST_RM2     = 5'd10;
    localparam logic [4:0] ST_RM3     = 5'd11;
    localparam logic [4:0] ST_RM4     = 5'd12;
    localparam logic [4:0] ST_RDIV    = 5'd13;
    localparam logic [4:0] ST_RWAIT   = 5'd14;
    localparam logic [4:0] ST_C0      = 5'd15;
    localparam logic [4:0] ST_C1      = 5'd16;
    localparam logic [4:0] ST_C2      = 5'd17;
    localparam logic [4:0] ST_OUT     = 5'd18;

    localparam logic [2:0] LAST_RAMP = 3'd5;

    logic [4:0]  r_state;
    logic [4:0]  r_ret;
    logic        r_pick;

    logic [21:0] r_min;
    logic [21:0] r_max;
    logic [31:0] r_seed;

    logic [1:0]  r_cur;
    logic [1:0]  r_last;
    logic [31:0] r_start;
    logic [32:0] r_due;
    logic [31:0] r_rng;

    logic [31:0] r_now;
    logic        r_restart;
    logic        r_trigger;
    logic        r_busy;

    logic [T_W-1:0]   r_t;
    logic [2:0]       r_ri;
    logic [9:0]       r_n;
    logic [9:0]       r_d;
    logic [27:0]      r_pa;
    logic [27:0]      r_pe;
    logic [Q_W-1:0]   r_rv [0:5];
    logic [Q_W-1:0]   r_pr;
    logic [Q_W-1:0]   r_ol;
    logic [Q_W-1:0]   r_x;

    logic             r_ov;
    logic             r_o_active;
    logic             r_o_visible;
    logic [1:0]       r_o_kind;
    logic [Q_W-1:0]   r_o_ol;
    logic [Q_W-1:0]   r_o_or;
    logic [13:0]      r_o_gaze;
    logic [Q_W-1:0]   r_o_sm;
    logic [Q_W-1:0]   r_o_pr;

    // shared multiplier
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [24:0] qsum;
    logic [Q_W-1:0] qres;

    t_div_req             div_req;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_Q_W-1:0]   div_quot;
    logic [DIV_DEN_W-1:0] div_rem;

    logic [22:0]    gap_den;
    logic [31:0]    elapsed;
    logic [T_W-1:0] cur_len;
    logic [1:0]     next_anim;
    logic [1:0]     pick;
    t_span          span;
    logic [10:0]    cubic_b;
    logic [Q_W-1:0] wk;
    logic [13:0]    gaze_v;
    logic           frame_go;

    // remainder by three from base-four digit sums, since four is one modulo three
    function automatic logic [1:0] mod3(input logic [30:0] x);
        logic [5:0] s;
        logic [3:0] u;
        logic [2:0] v;
        logic [1:0] m;
        s = 6'(x[30]);
        for (int k = 0; k < 15; k++)
            s = s + 6'(x[2*k +: 2]);
        u = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        v = 3'(u[1:0]) + 3'(u[3:2]);
        case (v)
            3'd1, 3'd4: m = 2'd1;
            3'd2, 3'd5: m = 2'd2;
            default:    m = 2'd0;
        endcase
        return m;
    endfunction

    eas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign gap_den   = (r_max >= r_min) ? ({1'b0, r_max} - {1'b0, r_min} + 23'd1) : 23'd1;
    assign elapsed   = r_now - r_start;
    assign cur_len   = anim_len(r_cur);
    assign next_anim = (r_last == ANIM_SMILE) ? ANIM_LOOK : r_last + 2'd1;
    assign pick      = 2'd1 + mod3(r_rng[31:1]);
    assign span      = ramp_span(r_cur, r_ri, r_t);
    assign cubic_b   = {r_d, 1'b0} + {1'b0, r_d} - {r_n, 1'b0};
    assign frame_go  = (!r_ov || i_out_ready);

    // wink closes the right eye in the middle of the animation
    always_comb begin
        if (r_t >= T_W'(900) && r_t < T_W'(1100))
            wk = Q_ONE - r_rv[4];
        else if (r_t >= T_W'(1100) && r_t < T_W'(1260))
            wk = '0;
        else if (r_t >= T_W'(1260) && r_t < T_W'(1460))
            wk = r_rv[4];
        else
            wk = Q_ONE;
    end

    always_comb begin
        if (r_t < T_W'(1150))
            gaze_v = 14'd0 - {1'b0, r_rv[4]};
        else if (r_t < T_W'(1450))
            gaze_v = 14'd0 - {1'b0, Q_ONE};
        else if (r_t < T_W'(2050))
            gaze_v = {r_rv[4], 1'b0} - {1'b0, Q_ONE};
        else if (r_t < T_W'(2350))
            gaze_v = {1'b0, Q_ONE};
        else
            gaze_v = {1'b0, Q_ONE - r_rv[4]};
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_DRAW: begin
                mul_a = r_rng;
                mul_b = LCG_MUL;
            end
            ST_RM1: begin
                mul_a = 32'(r_n);
                mul_b = 32'(r_n);
            end
            ST_RM2: begin
                mul_a = 32'(r_pa);
                mul_b = 32'(cubic_b);
            end
            ST_RM3: begin
                mul_a = 32'(r_d);
                mul_b = 32'(r_d);
            end
            ST_RM4: begin
                mul_a = 32'(r_pe);
                mul_b = 32'(r_d);
            end
            ST_C0: begin
                mul_a = 32'(r_rv[0]);
                mul_b = 32'(Q_ONE - r_rv[1]);
            end
            ST_C1: begin
                mul_a = 32'(r_rv[2]);
                mul_b = 32'(Q_ONE - r_rv[3]);
            end
            ST_C2: begin
                mul_a = (r_cur == ANIM_WINK) ? 32'(r_ol) : 32'(r_rv[4]);
                mul_b = (r_cur == ANIM_WINK) ? 32'(wk) : 32'(Q_ONE - r_rv[5]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign qsum  = mul_p[24:0] + 25'(1 << (FRAC_BITS - 1));
    assign qres  = qsum[24:FRAC_BITS];

    // the divisor is held for the whole division, not only at its start
    always_comb begin
        div_req.start     = (r_state == ST_DIVGO && !r_pick) || (r_state == ST_RDIV);
        div_req.long_mode = (r_state == ST_DIVGO);
        if (r_state == ST_DIVGO || r_state == ST_DIVWAIT) begin
            div_num = DIV_NUM_W'(r_rng[31:1]);
            div_den = DIV_DEN_W'(gap_den);
        end else begin
            div_num = {r_pa, FRAC_BITS'(0)} + DIV_NUM_W'(r_pe[27:1]);
            div_den = DIV_DEN_W'(r_pe);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min  <= 22'd20000;
            r_max  <= 22'd60000;
            r_seed <= 32'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_GAP: r_min  <= i_cfg_data[21:0];
                CFG_MAX_GAP: r_max  <= i_cfg_data[21:0];
                CFG_SEED:    r_seed <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_OUT && frame_go) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_pick  <= 1'b0;
            r_cur   <= ANIM_NONE;
            r_last  <= ANIM_NONE;
            r_start <= '0;
            r_due   <= '0;
            r_rng   <= 32'd1;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_now     <= i_now_ms;
                        r_restart <= i_restart;
                        r_trigger <= i_trigger;
                        r_busy    <= i_busy_req;
                        r_state   <= ST_RESTART;
                    end
                end
                ST_RESTART: begin
                    if (r_restart) begin
                        r_cur   <= ANIM_NONE;
                        r_last  <= ANIM_NONE;
                        r_start <= '0;
                        r_rng   <= r_seed | 32'd1;
                        r_pick  <= 1'b0;
                        r_ret   <= ST_TRIG;
                        r_state <= ST_DRAW;
                    end else begin
                        r_state <= ST_TRIG;
                    end
                end
                ST_TRIG: begin
                    if (r_trigger) begin
                        r_cur   <= next_anim;
                        r_last  <= next_anim;
                        r_start <= r_now;
                    end
                    r_state <= ST_SCHED;
                end
                ST_SCHED: begin
                    r_state <= ST_FRAME;
                    if (r_cur != ANIM_NONE) begin
                        if (r_now >= r_start && elapsed >= 32'(cur_len)) begin
                            r_cur   <= ANIM_NONE;
                            r_pick  <= 1'b0;
                            r_ret   <= ST_FRAME;
                            r_state <= ST_DRAW;
                        end
                    end else if ({1'b0, r_now} >= r_due) begin
                        if (r_busy) begin
                            r_due <= {1'b0, r_now} + BUSY_DELAY;
                        end else begin
                            r_pick  <= 1'b1;
                            r_state <= ST_DRAW;
                        end
                    end
                end
                ST_DRAW: begin
                    r_rng   <= mul_p[31:0] + LCG_INC;
                    r_state <= ST_DIVGO;
                end
                ST_DIVGO: begin
                    if (!r_pick) begin
                        r_state <= ST_DIVWAIT;
                    end else if (pick == r_last) begin
                        r_state <= ST_DRAW;
                    end else begin
                        r_cur   <= pick;
                        r_last  <= pick;
                        r_start <= r_now;
                        r_state <= ST_FRAME;
                    end
                end
                ST_DIVWAIT: begin
                    if (!div_busy) begin
                        r_due   <= {1'b0, r_now} + 33'(r_min) + 33'(div_rem);
                        r_state <= r_ret;
                    end
                end
                ST_FRAME: begin
                    r_ri <= '0;
                    if (r_now < r_start)
                        r_t <= '0;
                    else if (elapsed > 32'(cur_len))
                        r_t <= cur_len;
                    else
                        r_t <= elapsed[T_W-1:0];
                    r_state <= (r_cur == ANIM_NONE) ? ST_OUT : ST_RSET;
                end
                ST_RSET: begin
                    r_n <= 10'(r_t - span.t0);
                    r_d <= 10'(span.t1 - span.t0);
                    if (r_t <= span.t0 || r_t >= span.t1) begin
                        r_rv[r_ri] <= (r_t <= span.t0) ? '0 : Q_ONE;
                        r_ri       <= r_ri + 3'd1;
                        r_state    <= (r_ri == LAST_RAMP) ? ST_C0 : ST_RSET;
                    end else begin
                        r_state <= ST_RM1;
                    end
                end
                ST_RM1: begin
                    r_pa    <= mul_p[27:0];
                    r_state <= ST_RM2;
                end
                ST_RM2: begin
                    r_pa    <= mul_p[27:0];
                    r_state <= ST_RM3;
                end
                ST_RM3: begin
                    r_pe    <= mul_p[27:0];
                    r_state <= ST_RM4;
                end
                ST_RM4: begin
                    r_pe    <= mul_p[27:0];
                    r_state <= ST_RDIV;
                end
                ST_RDIV: begin
                    r_state <= ST_RWAIT;
                end
                ST_RWAIT: begin
                    if (!div_busy) begin
                        r_rv[r_ri] <= div_quot[Q_W-1:0];
                        r_ri       <= r_ri + 3'd1;
                        r_state    <= (r_ri == LAST_RAMP) ? ST_C0 : ST_RSET;
                    end
                end
                ST_C0: begin
                    r_pr    <= qres;
                    r_state <= ST_C1;
                end
                ST_C1: begin
                    r_ol    <= qres;
                    r_state <= ST_C2;
                end
                ST_C2: begin
                    r_x     <= qres;
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (frame_go) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output payload, zero on an idle tick
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && frame_go) begin
            if (r_cur == ANIM_NONE) begin
                r_o_active  <= 1'b0;
                r_o_visible <= 1'b0;
                r_o_kind    <= ANIM_NONE;
                r_o_ol      <= '0;
                r_o_or      <= '0;
                r_o_gaze    <= '0;
                r_o_sm      <= '0;
                r_o_pr      <= '0;
            end else begin
                r_o_active  <= 1'b1;
                r_o_visible <= (r_pr > VIS_LIMIT);
                r_o_kind    <= r_cur;
                r_o_ol      <= r_ol;
                r_o_or      <= (r_cur == ANIM_WINK) ? r_x : r_ol;
                r_o_gaze    <= (r_cur == ANIM_LOOK) ? gaze_v : '0;
                r_o_sm      <= (r_cur == ANIM_SMILE) ? r_x : '0;
                r_o_pr      <= r_pr;
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_active       = r_o_active;
    assign o_visible      = r_o_visible;
    assign o_anim_kind    = r_o_kind;
    assign o_open_left    = r_o_ol;
    assign o_open_right   = r_o_or;
    assign o_gaze         = signed'(r_o_gaze);
    assign o_smile_amount = r_o_sm;
    assign o_presence     = r_o_pr;

`ifndef SYNTHESIS
    a_one_tick_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("tick taken while another is in flight");

    a_running_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur != ANIM_NONE) |-> (r_last == r_cur))
        else $error("running animation differs from last animation");

    a_idle_frame_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_active) |-> (o_presence == '0 && o_anim_kind == ANIM_NONE))
        else $error("idle frame carries content");

    a_active_has_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_active) |-> (o_anim_kind != ANIM_NONE))
        else $error("active frame without animation kind");

    a_div_done_before_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIVGO && !r_pick) || r_state == ST_RDIV) |=> div_busy)
        else $error("divider did not start");
`endif

endmodule

`default_nettype wire

// File: tb/tb_eye_animation_sequencer.sv
`timescale 1ns / 1ps

module tb_eye_animation_sequencer;
    import eas_pkg::*;

    typedef struct {
        logic [31:0] now_ms;
        logic        restart;
        logic        trigger;
        logic        busy;
    } tick_t;

    typedef struct {
        logic        active;
        logic        visible;
        logic [1:0]  kind;
        logic [12:0] open_l;
        logic [12:0] open_r;
        logic [13:0] gaze;
        logic [12:0] smile;
        logic [12:0] presence;
    } frame_t;

    localparam logic [63:0] ONE = 64'(Q_ONE);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [31:0] i_now_ms = '0;
    logic i_restart = 1'b0;
    logic i_trigger = 1'b0;
    logic i_busy_req = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_active;
    logic o_visible;
    logic [1:0] o_anim_kind;
    logic [12:0] o_open_left;
    logic [12:0] o_open_right;
    logic signed [13:0] o_gaze;
    logic [12:0] o_smile_amount;
    logic [12:0] o_presence;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    eye_animation_sequencer dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state and register copies
    logic [21:0] gap_min = 22'd20000;
    logic [21:0] gap_max = 22'd60000;
    logic [31:0] seed_reg = 32'd1;
    logic [1:0]  cur_kind = ANIM_NONE;
    logic [1:0]  prev_kind = ANIM_NONE;
    logic [63:0] t_start = '0;
    logic [63:0] t_due = '0;
    logic [31:0] lcg = 32'd1;

    tick_t  tick_q[$];
    frame_t frame_q[$];
    tick_t  cur_tick;
    bit     quiet = 1'b0;
    int     errors = 0;
    logic [31:0] clock_ms = '0;

    function automatic logic [31:0] lcg_draw();
        lcg = lcg * LCG_MUL + LCG_INC;
        return lcg >> 1;
    endfunction

    function automatic void schedule_gap(input logic [63:0] now);
        logic [63:0] r;
        logic [63:0] span;
        r = 64'(lcg_draw());
        span = (gap_max >= gap_min) ? 64'(gap_max - gap_min) : 64'd0;
        t_due = now + 64'(gap_min) + (r % (span + 64'd1));
    endfunction

    function automatic void launch_anim(input logic [63:0] now, input logic [1:0] kind);
        logic [1:0] pick;
        if (kind == ANIM_NONE) begin
            do
                pick = 2'(1 + (lcg_draw() % 3));
            while (pick == prev_kind);
            kind = pick;
        end
        cur_kind = kind;
        prev_kind = kind;
        t_start = now;
    endfunction

    function automatic logic [63:0] ramp_up(input logic [63:0] t, input logic [63:0] t0,
                                            input logic [63:0] t1);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] d3;
        if (t <= t0)
            return 64'd0;
        if (t >= t1)
            return ONE;
        n = t - t0;
        d = t1 - t0;
        d3 = d * d * d;
        return (n * n * (3 * d - 2 * n) * ONE + d3 / 2) / d3;
    endfunction

    function automatic logic [63:0] ramp_dn(input logic [63:0] t, input logic [63:0] t0,
                                            input logic [63:0] t1);
        return ONE - ramp_up(t, t0, t1);
    endfunction

    function automatic logic [63:0] qmul(input logic [63:0] p, input logic [63:0] q);
        return (p * q + ONE / 2) >> FRAC_BITS;
    endfunction

    function automatic logic [63:0] anim_ms(input logic [1:0] kind);
        case (kind)
            ANIM_LOOK:  return 64'd3200;
            ANIM_WINK:  return 64'd2600;
            ANIM_SMILE: return 64'd3000;
            default:    return 64'd0;
        endcase
    endfunction

    function automatic frame_t next_frame(input tick_t tk);
        frame_t f;
        logic [63:0] now;
        logic [63:0] t;
        logic [63:0] d;
        logic [63:0] pr;
        logic [63:0] ol;
        logic [63:0] orr;
        logic [63:0] sm;
        logic [63:0] gz;
        logic [63:0] s;
        logic [63:0] wk;
        logic [1:0] nx;
        bit gneg;
        now = 64'(tk.now_ms);
        pr = 0; ol = 0; orr = 0; sm = 0; gz = 0; gneg = 1'b0;
        if (tk.restart) begin
            cur_kind = ANIM_NONE;
            prev_kind = ANIM_NONE;
            t_start = 0;
            lcg = seed_reg | 32'd1;
            schedule_gap(now);
        end
        if (tk.trigger) begin
            nx = (prev_kind == ANIM_SMILE) ? ANIM_LOOK : prev_kind + 2'd1;
            launch_anim(now, nx);
        end
        if (cur_kind != ANIM_NONE) begin
            if (now >= t_start && now - t_start >= anim_ms(cur_kind)) begin
                cur_kind = ANIM_NONE;
                schedule_gap(now);
            end
        end else if (now >= t_due) begin
            if (tk.busy)
                t_due = now + 64'(BUSY_DELAY);
            else
                launch_anim(now, ANIM_NONE);
        end
        f = '{default: '0};
        if (cur_kind == ANIM_NONE)
            return f;
        d = anim_ms(cur_kind);
        t = (now >= t_start) ? now - t_start : 64'd0;
        if (t > d)
            t = d;
        case (cur_kind)
            ANIM_LOOK: begin
                pr = qmul(ramp_up(t, 0, 260), ramp_dn(t, 2940, 3200));
                ol = qmul(ramp_up(t, 180, 420), ramp_dn(t, 2700, 2940));
                orr = ol;
                if (t < 1150) begin
                    gz = ramp_up(t, 700, 1150);
                    gneg = 1'b1;
                end else if (t < 1450) begin
                    gz = ONE;
                    gneg = 1'b1;
                end else if (t < 2050) begin
                    s = ramp_up(t, 1450, 2050);
                    if (s * 2 >= ONE) begin
                        gz = s * 2 - ONE;
                    end else begin
                        gz = ONE - s * 2;
                        gneg = 1'b1;
                    end
                end else if (t < 2350) begin
                    gz = ONE;
                end else begin
                    gz = ramp_dn(t, 2350, 2650);
                end
            end
            ANIM_WINK: begin
                wk = ONE;
                pr = qmul(ramp_up(t, 0, 260), ramp_dn(t, 2340, 2600));
                ol = qmul(ramp_up(t, 180, 420), ramp_dn(t, 2100, 2340));
                if (t >= 900 && t < 1100)
                    wk = ramp_dn(t, 900, 1100);
                else if (t >= 1100 && t < 1260)
                    wk = 0;
                else if (t >= 1260 && t < 1460)
                    wk = ramp_up(t, 1260, 1460);
                orr = qmul(ol, wk);
            end
            default: begin
                pr = qmul(ramp_up(t, 0, 260), ramp_dn(t, 2740, 3000));
                ol = qmul(ramp_up(t, 180, 420), ramp_dn(t, 1000, 1200));
                orr = ol;
                sm = qmul(ramp_up(t, 1200, 1400), ramp_dn(t, 2300, 2500));
            end
        endcase
        f.active = 1'b1;
        f.visible = (pr > 64'(VIS_LIMIT));
        f.kind = cur_kind;
        f.open_l = 13'(ol);
        f.open_r = 13'(orr);
        f.gaze = 14'(gneg ? (64'd0 - gz) : gz);
        f.smile = 13'(sm);
        f.presence = 13'(pr);
        return f;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
            errors++;
        end
    endtask

    // driver: tick transactions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                frame_q.push_back(next_frame(cur_tick));
            if (!i_in_valid || o_in_ready) begin
                if (tick_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 27)) begin
                    cur_tick = tick_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_now_ms <= cur_tick.now_ms;
                    i_restart <= cur_tick.restart;
                    i_trigger <= cur_tick.trigger;
                    i_busy_req <= cur_tick.busy;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: frame transactions
    always @(posedge i_clk) begin
        frame_t w;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (frame_q.size() == 0) begin
                    report("unexpected frame", 32'd1, 32'd0);
                end else begin
                    w = frame_q.pop_front();
                    report("active", 32'(o_active), 32'(w.active));
                    report("visible", 32'(o_visible), 32'(w.visible));
                    report("anim_kind", 32'(o_anim_kind), 32'(w.kind));
                    report("open_left", 32'(o_open_left), 32'(w.open_l));
                    report("open_right", 32'(o_open_right), 32'(w.open_r));
                    report("gaze", 32'(unsigned'(o_gaze)), 32'(w.gaze));
                    report("smile_amount", 32'(o_smile_amount), 32'(w.smile));
                    report("presence", 32'(o_presence), 32'(w.presence));
                end
            end
            i_out_ready <= quiet || ($urandom_range(0, 99) >= 27);
        end
    end

    task automatic add_tick(input logic [31:0] now, input bit rs, input bit tr, input bit bz);
        tick_t tk;
        tk.now_ms = now;
        tk.restart = rs;
        tk.trigger = tr;
        tk.busy = bz;
        tick_q.push_back(tk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_GAP: gap_min = data[21:0];
            CFG_MAX_GAP: gap_max = data[21:0];
            CFG_SEED:    seed_reg = data;
            default:     ;
        endcase
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || i_in_valid || frame_q.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    // mostly small time steps so animations play through; occasional jumps
    task automatic random_ticks(input int count);
        int roll;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                clock_ms = clock_ms + $urandom_range(0, 300);
            else if (roll < 95)
                clock_ms = clock_ms + $urandom_range(0, 5000);
            else
                clock_ms = $urandom;
            add_tick(clock_ms, ($urandom_range(0, 99) < 3), ($urandom_range(0, 99) < 6),
                     ($urandom_range(0, 99) < 35));
        end
    endtask

    task automatic phase(input logic [21:0] lo, input logic [21:0] hi, input logic [31:0] sd,
                         input int count);
        drain();
        reg_write(CFG_MIN_GAP, 32'(lo));
        reg_write(CFG_MAX_GAP, 32'(hi));
        reg_write(CFG_SEED, sd);
        clock_ms = $urandom_range(0, 1000);
        add_tick(clock_ms, 1'b1, 1'b0, 1'b0);
        random_ticks(count);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        quiet = 1'b1;
        // due at reset with busy, idle, random start, backwards time, retrigger
        add_tick(32'd0, 1'b0, 1'b0, 1'b1);
        add_tick(32'd10, 1'b0, 1'b0, 1'b0);
        add_tick(32'd5000, 1'b0, 1'b0, 1'b0);
        add_tick(32'd5130, 1'b0, 1'b0, 1'b0);
        add_tick(32'd4000, 1'b0, 1'b0, 1'b0);
        add_tick(32'd6000, 1'b0, 1'b1, 1'b0);
        add_tick(32'd9300, 1'b0, 1'b0, 1'b0);
        // restart and trigger together, then look, wink, smile in turn
        add_tick(32'd9400, 1'b1, 1'b1, 1'b0);
        add_tick(32'd10500, 1'b0, 1'b0, 1'b0);
        add_tick(32'd11000, 1'b0, 1'b0, 1'b0);
        add_tick(32'd12300, 1'b0, 1'b0, 1'b0);
        add_tick(32'd12600, 1'b0, 1'b0, 1'b0);
        add_tick(32'd13000, 1'b0, 1'b1, 1'b0);
        add_tick(32'd13950, 1'b0, 1'b0, 1'b0);
        add_tick(32'd14200, 1'b0, 1'b0, 1'b0);
        add_tick(32'd14350, 1'b0, 1'b0, 1'b0);
        add_tick(32'd15600, 1'b0, 1'b0, 1'b0);
        add_tick(32'd16000, 1'b0, 1'b1, 1'b0);
        add_tick(32'd17300, 1'b0, 1'b0, 1'b0);
        add_tick(32'd18400, 1'b0, 1'b0, 1'b0);
        add_tick(32'd19000, 1'b0, 1'b0, 1'b0);
        add_tick(32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0);
        add_tick(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
        drain();
        quiet = 1'b0;
        phase(22'd100, 22'd2000, $urandom, 150);
        phase(22'd0, 22'h3F_FFFF, 32'd0, 50);
        phase(22'd3000, 22'd50, 32'hFFFF_FFFF, 100);
        phase(22'd0, 22'd0, $urandom, 100);
        phase(22'h3F_FFFF, 22'h3F_FFFF, $urandom, 30);
        phase(22'd500, 22'd4000, $urandom, 80);
        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/eas_pkg.sv
hw/rtl/eas_div.sv
hw/rtl/eye_animation_sequencer.sv
tb/tb_eye_animation_sequencer.sv
